// ===== sv/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_WRITE_MATRIX = 2'd0,
        OP_WRITE_RHS    = 2'd1,
        OP_SOLVE        = 2'd2,
        OP_NONE         = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [3:0]               row;
        logic [3:0]               column;
        logic signed [DATA_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]               index;
        logic signed [DATA_W-1:0] solution;
        logic                     last;
        logic                     skipped;
        logic                     saturated;
    } result_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_RESID,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

endpackage

// ===== sv/gauss_seidel_solver_top.sv =====
// ----------------------------------------------------------------------------
// gauss_seidel_solver_top
// Fixed-point Gauss-Seidel solver with matrix and right-hand stores.
// ----------------------------------------------------------------------------
// A write command is accepted whenever the solver is idle. A solve runs n
// sweeps of n rows; a row with a nonzero diagonal runs its multiply-accumulate
// through the shared multiplier, then a residual step and the bit-serial
// divider; a row with a zero diagonal is skipped. The n results then follow
// one at a time. busy stays high for the whole solve, and each result is
// shown for one cycle on result_valid with no way to hold it off.
module gauss_seidel_solver_top #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gss_pkg::cmd_item_t   cmd,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    output logic                 result_valid,
    output gss_pkg::result_item_t result
);

    import gss_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int ADDR_W = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int DVD_W  = DATA_W + FRAC_BITS;
    localparam int SUM_W  = DVD_W + 2;

    state_t state_reg, state_next;

    logic [4:0]              size_reg;
    logic [IDX_W-1:0]        nm1_reg;
    logic [IDX_W-1:0]        nm1_calc;
    logic [IDX_W-1:0]        i_reg, j_reg, k_reg, sweep_reg;
    logic [MAX_SIZE-1:0]     vld_reg;
    logic                    skip_reg, sat_reg;
    logic signed [DATA_W-1:0] diag_reg, b_reg, xi_reg, res_reg;
    logic signed [63:0]      prod_reg, acc_reg;
    logic                    rvld_reg;
    int                      sz;

    // ram ports
    logic                    a_we;
    logic [ADDR_W-1:0]       a_waddr, a_raddr;
    logic [DATA_W-1:0]       a_rdata;
    logic                    b_we;
    logic [IDX_W-1:0]        b_waddr, b_raddr;
    logic [DATA_W-1:0]       b_rdata;
    logic                    x_we;
    logic [IDX_W-1:0]        x_waddr, x_raddr;
    logic [DATA_W-1:0]       x_wdata, x_rdata;
    logic signed [DATA_W-1:0] x_val;

    // divider
    logic                    div_start, div_done;
    logic [DVD_W-1:0]        div_q;
    logic [DATA_W-1:0]       res_mag, diag_mag;

    // arithmetic
    logic signed [64:0]      diff;
    logic signed [DATA_W-1:0] res_sat;
    logic                    res_ovf;
    logic signed [DVD_W:0]   step;
    logic signed [SUM_W-1:0] sum;
    logic signed [DATA_W-1:0] x_new;
    logic                    x_ovf;

    logic accept, last_row, last_sweep, advance_row;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        sz = int'(size_reg);
        if (sz < 1)
        begin
            sz = 1;
        end
        if (sz > MAX_SIZE)
        begin
            sz = MAX_SIZE;
        end
        nm1_calc = IDX_W'(sz - 1);
    end

    gss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_matrix (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(cmd.value),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    gss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_rhs (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(cmd.value),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    gss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_solution (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rdata)
    );

    gss_divider #(.DVD_W(DVD_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({res_mag, FRAC_BITS'(0)}), .divisor(diag_mag),
        .done(div_done), .quotient(div_q)
    );

    // entry never written in this solve reads as zero
    assign x_val = rvld_reg ? signed'(x_rdata) : '0;

    assign last_row    = (i_reg == nm1_reg);
    assign last_sweep  = (sweep_reg == nm1_reg);
    assign advance_row = (state_reg == ST_UPDATE)
                      || (state_reg == ST_ROW_CHK && signed'(a_rdata) == 0);

    // arithmetic for residual and update
    always_comb
    begin
        diff    = 65'(b_reg) - 65'(acc_reg);
        res_ovf = 1'b1;
        if (diff > 65'(S32_MAX))
        begin
            res_sat = S32_MAX;
        end
        else if (diff < 65'(S32_MIN))
        begin
            res_sat = S32_MIN;
        end
        else
        begin
            res_sat = DATA_W'(diff);
            res_ovf = 1'b0;
        end
        res_mag  = res_reg[DATA_W-1] ? DATA_W'(-res_reg) : res_reg;
        diag_mag = diag_reg[DATA_W-1] ? DATA_W'(-diag_reg) : diag_reg;
        step     = (res_reg[DATA_W-1] ^ diag_reg[DATA_W-1])
                 ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
        sum      = SUM_W'(xi_reg) + SUM_W'(step);
        x_ovf    = 1'b1;
        if (sum > SUM_W'(S32_MAX))
        begin
            x_new = S32_MAX;
        end
        else if (sum < SUM_W'(S32_MIN))
        begin
            x_new = S32_MIN;
        end
        else
        begin
            x_new = DATA_W'(sum);
            x_ovf = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.operation == OP_SOLVE)
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_CHK;
            end
            ST_ROW_CHK:
            begin
                if (signed'(a_rdata) == 0)
                begin
                    state_next = (last_row && last_sweep) ? ST_OUT_RD : ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_MAC_MUL;
                end
            end
            ST_MAC_MUL:
            begin
                state_next = ST_MAC_ACC;
            end
            ST_MAC_ACC:
            begin
                state_next = (j_reg == nm1_reg) ? ST_RESID : ST_MAC_MUL;
            end
            ST_RESID:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (last_row && last_sweep) ? ST_OUT_RD : ST_ROW_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                state_next = (k_reg == nm1_reg) ? ST_IDLE : ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        a_we         = 1'b0;
        b_we         = 1'b0;
        x_we         = 1'b0;
        div_start    = 1'b0;
        result_valid = 1'b0;
        a_waddr      = ADDR_W'(IDX_W'(cmd.row)) * ADDR_W'(MAX_SIZE)
                     + ADDR_W'(IDX_W'(cmd.column));
        b_waddr      = IDX_W'(cmd.row);
        x_waddr      = i_reg;
        x_wdata      = x_new;
        a_raddr      = ADDR_W'(i_reg) * ADDR_W'(MAX_SIZE) + ADDR_W'(i_reg);
        b_raddr      = i_reg;
        x_raddr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.operation == OP_WRITE_MATRIX)
                begin
                    a_we = (32'(cmd.row) < MAX_SIZE) && (32'(cmd.column) < MAX_SIZE);
                end
                if (accept && cmd.operation == OP_WRITE_RHS)
                begin
                    b_we = (32'(cmd.row) < MAX_SIZE);
                end
            end
            ST_ROW_CHK:
            begin
                a_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_SIZE);
                x_raddr = '0;
            end
            ST_MAC_ACC:
            begin
                a_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_SIZE) + ADDR_W'(j_reg + 1'b1);
                x_raddr = j_reg + 1'b1;
            end
            ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            ST_UPDATE:
            begin
                x_we = 1'b1;
            end
            ST_OUT_RD:
            begin
                x_raddr = k_reg;
            end
            ST_OUT_EMIT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.index     = 4'(k_reg);
        result.solution  = x_val;
        result.last      = (k_reg == nm1_reg);
        result.skipped   = skip_reg;
        result.saturated = sat_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= 5'd16;
            nm1_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sweep_reg <= '0;
            vld_reg   <= '0;
            skip_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rvld_reg  <= vld_reg[x_raddr];
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (accept && cmd.operation == OP_SOLVE)
            begin
                nm1_reg   <= nm1_calc;
                i_reg     <= '0;
                sweep_reg <= '0;
                k_reg     <= '0;
                vld_reg   <= '0;
                skip_reg  <= 1'b0;
                sat_reg   <= 1'b0;
            end
            if (state_reg == ST_ROW_CHK)
            begin
                j_reg <= '0;
                if (signed'(a_rdata) == 0)
                begin
                    skip_reg <= 1'b1;
                end
            end
            if (state_reg == ST_MAC_ACC)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == ST_RESID && res_ovf)
            begin
                sat_reg <= 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                vld_reg[i_reg] <= 1'b1;
                if (x_ovf)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (advance_row)
            begin
                if (last_row)
                begin
                    i_reg     <= '0;
                    sweep_reg <= sweep_reg + 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            if (state_reg == ST_OUT_EMIT)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROW_CHK)
        begin
            diag_reg <= signed'(a_rdata);
            b_reg    <= signed'(b_rdata);
            acc_reg  <= '0;
            xi_reg   <= '0;
        end
        if (state_reg == ST_MAC_MUL)
        begin
            prod_reg <= signed'(a_rdata) * x_val;
            if (j_reg == i_reg)
            begin
                xi_reg <= x_val;
            end
        end
        if (state_reg == ST_MAC_ACC)
        begin
            // arithmetic shift rounds toward minus infinity
            acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
        end
        if (state_reg == ST_RESID)
        begin
            res_reg <= res_sat;
        end
    end

endmodule

// ===== sv/gss_ram.sv =====
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/gss_divider.sv =====
// ----------------------------------------------------------------------------
// gss_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gss_divider #(
    parameter int DVD_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [31:0]      rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [31:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
